>>> hw/rtl/fbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbm_pkg: shared types, constants and twiddle table for the mip builder
// Frame geometry, FSM states, operation/status codes, sine quarter-wave ROM.
// ----------------------------------------------------------------------------
package fbm_pkg;

  localparam int MAX_FRAME  = 2048;
  localparam int MAX_LEVEL  = 8;
  localparam int AW         = $clog2(MAX_FRAME);   // frame address width
  localparam int QUARTER    = MAX_FRAME / 4;
  localparam int LEVEL_W    = 4;
  localparam int INDEX_W    = 11;
  localparam int SAMPLE_W   = 16;
  localparam int LOG_W      = 4;
  localparam int STATUS_W   = 2;
  localparam int BIN_W      = 24;                  // Q1.22 bin half
  localparam int TW_W       = 22;                  // signed Q1.20 twiddle
  localparam int PROD_W     = BIN_W + TW_W;
  localparam int ACC_W      = 58;
  localparam logic [LOG_W-1:0] FRAME_LOG2_RST = 4'd11;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_BUILT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd2;

  // series denominators as reciprocals; floor is exact for dividends below 2^31
  localparam int          RCP_SH  = 39;
  localparam logic [63:0] RCP_ONE = 64'd1 << RCP_SH;
  localparam logic [63:0] RCP_2   = (RCP_ONE + 64'd1) / 64'd2;
  localparam logic [63:0] RCP_6   = (RCP_ONE + 64'd5) / 64'd6;
  localparam logic [63:0] RCP_12  = (RCP_ONE + 64'd11) / 64'd12;
  localparam logic [63:0] RCP_20  = (RCP_ONE + 64'd19) / 64'd20;
  localparam logic [63:0] RCP_30  = (RCP_ONE + 64'd29) / 64'd30;
  localparam logic [63:0] RCP_42  = (RCP_ONE + 64'd41) / 64'd42;
  localparam logic [63:0] RCP_56  = (RCP_ONE + 64'd55) / 64'd56;
  localparam logic [63:0] RCP_72  = (RCP_ONE + 64'd71) / 64'd72;
  localparam logic [63:0] RCP_90  = (RCP_ONE + 64'd89) / 64'd90;
  localparam logic [63:0] RCP_110 = (RCP_ONE + 64'd109) / 64'd110;
  localparam logic [63:0] RCP_132 = (RCP_ONE + 64'd131) / 64'd132;
  localparam logic [63:0] RCP_156 = (RCP_ONE + 64'd155) / 64'd156;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_FWD,
    ST_FWD_DRAIN,
    ST_INV,
    ST_INV_DRAIN
  } state_t;

  // control that travels with each multiply-accumulate step
  typedef struct packed {
    logic vld;
    logic fwd;
    logic first;
    logic last;
    logic zero;
    logic dbl;
  } mac_ctl_t;

  typedef struct packed {
    logic          neg;
    logic [AW-2:0] idx;
  } tw_addr_t;

  typedef logic [TW_W-2:0] sine_rom_t [0:QUARTER];

  function automatic logic [63:0] taylor(logic [63:0] x, logic is_sine);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        prod;
    logic [63:0]        rcp;
    logic [127:0]       wide;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = is_sine ? x : (64'd1 << 30);
    sum  = $signed(term);
    for (int n = 1; n <= 6; n++) begin
      case (n)
        1:       rcp = is_sine ? RCP_6   : RCP_2;
        2:       rcp = is_sine ? RCP_20  : RCP_12;
        3:       rcp = is_sine ? RCP_42  : RCP_30;
        4:       rcp = is_sine ? RCP_72  : RCP_56;
        5:       rcp = is_sine ? RCP_110 : RCP_90;
        default: rcp = is_sine ? RCP_156 : RCP_132;
      endcase
      prod = (term * x2) >> 30;
      wide = 128'(prod) * 128'(rcp);
      term = 64'(wide >> RCP_SH);
      if ((n & 1) == 1) sum = sum - $signed(term);
      else              sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
    return sum;
  endfunction

  function automatic sine_rom_t make_sine_rom();
    sine_rom_t   rom;
    logic [63:0] v;
    for (int m = 0; m <= QUARTER; m++) begin
      if (m <= QUARTER / 2)
        v = taylor((TWO_PI_Q30 * 64'(m)) >> AW, 1'b1);
      else
        v = taylor((TWO_PI_Q30 * 64'(QUARTER - m)) >> AW, 1'b0);
      rom[m] = (TW_W-1)'((v + 64'd512) >> 10);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = make_sine_rom();

  // quarter-wave folding of a phase in MAX_FRAME units
  function automatic tw_addr_t tw_lookup(logic [AW-1:0] p);
    tw_addr_t   r;
    logic [AW:0] pe;
    pe = {1'b0, p};
    if (pe <= (AW+1)'(QUARTER)) begin
      r.neg = 1'b0;
      r.idx = (AW-1)'(pe);
    end else if (pe <= (AW+1)'(2*QUARTER)) begin
      r.neg = 1'b0;
      r.idx = (AW-1)'((AW+1)'(2*QUARTER) - pe);
    end else if (pe <= (AW+1)'(3*QUARTER)) begin
      r.neg = 1'b1;
      r.idx = (AW-1)'(pe - (AW+1)'(2*QUARTER));
    end else begin
      r.neg = 1'b1;
      r.idx = (AW-1)'((AW+1)'(4*QUARTER) - pe);
    end
    return r;
  endfunction

  function automatic logic [BIN_W-1:0] sat_bin(logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(8388607))        return 24'h7FFFFF;
    else if (v < -ACC_W'(8388608))  return 24'h800000;
    else                            return v[BIN_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] sat_smp(logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(32767))          return 16'h7FFF;
    else if (v < -ACC_W'(32768))    return 16'h8000;
    else                            return v[SAMPLE_W-1:0];
  endfunction

endpackage

>>> hw/rtl/fbm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fbm_ram #(
  parameter int W = 16,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/fft_bandlimited_mip_builder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fft_bandlimited_mip_builder_top: band-limited wavetable mip-map builder
// Loads a frame, builds all mip levels by DFT / truncated inverse DFT, serves
// reads of single level samples.
// ----------------------------------------------------------------------------
// A transfer is taken when start is high and busy is low. A load transfer
// (operation 0) gives no result; the load that carries last starts the build,
// with busy high, if frame_log2 is at least MAX_LEVEL, else only marks the
// levels not built. The build is a single multiply-accumulate pipeline fed
// from the frame and spectrum memories, one step per cycle: the forward pass
// takes a step per frame sample for each of N/2 bins (N = 2^frame_log2, at
// most 2048), the inverse pass a step per kept bin (at least one) for each
// sample of every level; a pipeline drain follows each pass. A read transfer
// (operation 1) gives one result: a valid read passes the read state (one mip
// memory read) with busy high for one cycle and then returns its sample; a
// read that is refused (not built, level or index out of range) returns next
// cycle without busy. Every result sits on out_value/out_status for exactly
// one cycle with out_valid high; the receiver cannot stall it. The user writes
// frame_log2 through cfg_wr_en/cfg_wr_data only while the block is idle; the
// block does not enforce it. Reads use the frame length latched when the last
// build started; old levels stay readable while a new frame is loading.
// ----------------------------------------------------------------------------
module fft_bandlimited_mip_builder_top
  import fbm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  // command channel
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_operation,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last,
  input  logic [LEVEL_W-1:0]         in_level,
  input  logic [INDEX_W-1:0]         in_index,
  // result channel
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_value,
  output logic [STATUS_W-1:0]        out_status,
  // configuration
  input  logic                       cfg_wr_en,
  input  logic [LOG_W-1:0]           cfg_wr_data
);

  localparam int SPEC_AW = AW - 1;
  localparam int MIP_AW  = AW + 1;

  // ---------------- control registers ----------------
  state_t                state_r, state_nxt;
  logic [LOG_W-1:0]      frame_log2_r, frame_log2_nxt;
  logic [AW:0]           load_cnt_r, load_cnt_nxt;
  logic [AW:0]           bld_cnt_r, bld_cnt_nxt;
  logic [LOG_W-1:0]      bld_lg_r, bld_lg_nxt;
  logic                  built_r, built_nxt;
  logic [SPEC_AW-1:0]    k_r, k_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [AW-1:0]         ph_r, ph_nxt;
  logic [AW-1:0]         d_r, d_nxt;
  logic [LEVEL_W-1:0]    lvl_r, lvl_nxt;
  logic [MIP_AW-1:0]     wr_cnt_r, wr_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]   out_value_r, out_value_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;

  // ---------------- pipeline registers ----------------
  mac_ctl_t                 issue;
  mac_ctl_t                 s1_ctl_r, s2_ctl_r, s3_ctl_r;
  logic signed [TW_W-1:0]   sin_r, cos_r;
  logic signed [PROD_W-1:0] pa_r, pb_r;
  logic signed [ACC_W-1:0]  acc_re_r;
  logic signed [ACC_W-1:0]  acc_im_r;
  logic                     wb_vld_r;
  logic                     wb_fwd_r;
  logic [2*BIN_W-1:0]       wb_data_r;

  // ---------------- memories ----------------
  logic                     frame_we;
  logic [SAMPLE_W-1:0]      frame_rdata;
  logic [2*BIN_W-1:0]       spec_rdata;
  logic [SAMPLE_W-1:0]      mip_rdata;
  logic                     spec_we, mip_we;
  logic [MIP_AW-1:0]        mip_raddr;

  // ---------------- derived values ----------------
  logic [LOG_W-1:0]   act_lg;
  logic [AW:0]        n_len;
  logic [AW:0]        bld_len;
  logic [AW:0]        half_fwd;
  logic [LOG_W-1:0]   fwd_sh;
  logic [AW-1:0]      kstep;
  logic [AW:0]        inv_size;
  logic [AW:0]        inv_half;
  logic [AW:0]        st_full;
  logic [AW-1:0]      st;
  logic [AW:0]        rd_size;
  logic [AW+1:0]      rd_off;
  logic [MIP_AW-1:0]  rd_addr;
  logic               rd_bad;
  logic [AW:0]        cnt_tmp;
  logic               pipe_busy;
  logic               fwd_last_n;
  logic               inv_last_k;

  assign act_lg   = (frame_log2_r > LOG_W'(AW)) ? LOG_W'(AW) : frame_log2_r;
  assign n_len    = (AW+1)'(1) << act_lg;
  assign bld_len  = (AW+1)'(1) << bld_lg_r;
  assign half_fwd = bld_len >> 1;
  assign fwd_sh   = LOG_W'(AW) - bld_lg_r;
  assign kstep    = {1'b0, k_r} << fwd_sh;
  assign inv_size = bld_len >> lvl_r;
  assign inv_half = inv_size >> 1;
  assign st_full  = (AW+1)'(1) << ((LOG_W+1)'(fwd_sh) + (LOG_W+1)'(lvl_r));
  assign st       = st_full[AW-1:0];

  // mip level L starts at 2N - 2*(N >> L)
  assign rd_size  = bld_len >> in_level;
  assign rd_off   = {bld_len, 1'b0} - {rd_size, 1'b0};
  assign rd_addr  = MIP_AW'(rd_off) + MIP_AW'(in_index);
  assign rd_bad   = (in_level > LEVEL_W'(MAX_LEVEL)) || ({1'b0, in_index} >= rd_size);

  assign pipe_busy  = s1_ctl_r.vld | s2_ctl_r.vld | s3_ctl_r.vld | wb_vld_r;
  assign fwd_last_n = (pos_r == AW'(bld_len - (AW+1)'(1)));
  assign inv_last_k = (inv_half == '0) || ((AW+1)'(k_r) + (AW+1)'(1) == inv_half);

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt      = state_r;
    frame_log2_nxt = frame_log2_r;
    load_cnt_nxt   = load_cnt_r;
    bld_cnt_nxt    = bld_cnt_r;
    bld_lg_nxt     = bld_lg_r;
    built_nxt      = built_r;
    k_nxt          = k_r;
    pos_nxt        = pos_r;
    ph_nxt         = ph_r;
    d_nxt          = d_r;
    lvl_nxt        = lvl_r;
    wr_cnt_nxt     = wr_cnt_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    frame_we       = 1'b0;
    cnt_tmp        = load_cnt_r;
    issue          = '0;

    if (cfg_wr_en) frame_log2_nxt = cfg_wr_data;
    if (wb_vld_r)  wr_cnt_nxt = wr_cnt_r + MIP_AW'(1);

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_operation == OP_LOAD) begin
            if (load_cnt_r < n_len) begin
              frame_we = 1'b1;
              cnt_tmp  = load_cnt_r + (AW+1)'(1);
            end
            load_cnt_nxt = cnt_tmp;
            if (in_last) begin
              load_cnt_nxt = '0;
              if (act_lg < LOG_W'(MAX_LEVEL)) begin
                built_nxt = 1'b0;
              end else begin
                bld_lg_nxt  = act_lg;
                bld_cnt_nxt = cnt_tmp;
                k_nxt       = '0;
                pos_nxt     = '0;
                ph_nxt      = '0;
                wr_cnt_nxt  = '0;
                state_nxt   = ST_FWD;
              end
            end
          end else begin
            if (!built_r) begin
              out_valid_nxt  = 1'b1;
              out_value_nxt  = '0;
              out_status_nxt = STAT_NOT_BUILT;
            end else if (rd_bad) begin
              out_valid_nxt  = 1'b1;
              out_value_nxt  = '0;
              out_status_nxt = STAT_RANGE;
            end else begin
              state_nxt = ST_READ;
            end
          end
        end
      end

      ST_READ: begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = mip_rdata;
        out_status_nxt = STAT_OK;
        state_nxt      = ST_IDLE;
      end

      ST_FWD: begin
        issue.vld   = 1'b1;
        issue.fwd   = 1'b1;
        issue.first = (pos_r == '0);
        issue.last  = fwd_last_n;
        issue.zero  = ({1'b0, pos_r} >= bld_cnt_r);
        issue.dbl   = 1'b0;
        if (fwd_last_n) begin
          pos_nxt = '0;
          ph_nxt  = '0;
          if ((AW+1)'(k_r) + (AW+1)'(1) == half_fwd) state_nxt = ST_FWD_DRAIN;
          else                                      k_nxt = k_r + SPEC_AW'(1);
        end else begin
          pos_nxt = pos_r + AW'(1);
          ph_nxt  = ph_r + kstep;
        end
      end

      ST_FWD_DRAIN: begin
        if (!pipe_busy) begin
          k_nxt      = '0;
          pos_nxt    = '0;
          ph_nxt     = '0;
          d_nxt      = '0;
          lvl_nxt    = '0;
          wr_cnt_nxt = '0;
          state_nxt  = ST_INV;
        end
      end

      ST_INV: begin
        issue.vld   = 1'b1;
        issue.fwd   = 1'b0;
        issue.first = (k_r == '0);
        issue.last  = inv_last_k;
        issue.zero  = (inv_half == '0);
        issue.dbl   = (k_r != '0);
        if (inv_last_k) begin
          k_nxt  = '0;
          ph_nxt = '0;
          if ((AW+1)'(pos_r) + (AW+1)'(1) == inv_size) begin
            pos_nxt = '0;
            d_nxt   = '0;
            if (lvl_r == LEVEL_W'(MAX_LEVEL)) state_nxt = ST_INV_DRAIN;
            else                              lvl_nxt = lvl_r + LEVEL_W'(1);
          end else begin
            pos_nxt = pos_r + AW'(1);
            d_nxt   = d_r + st;
          end
        end else begin
          k_nxt  = k_r + SPEC_AW'(1);
          ph_nxt = ph_r + d_r;
        end
      end

      ST_INV_DRAIN: begin
        if (!pipe_busy) begin
          built_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      frame_log2_r <= FRAME_LOG2_RST;
      load_cnt_r   <= '0;
      bld_cnt_r    <= '0;
      bld_lg_r     <= '0;
      built_r      <= 1'b0;
      k_r          <= '0;
      pos_r        <= '0;
      ph_r         <= '0;
      d_r          <= '0;
      lvl_r        <= '0;
      wr_cnt_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      frame_log2_r <= frame_log2_nxt;
      load_cnt_r   <= load_cnt_nxt;
      bld_cnt_r    <= bld_cnt_nxt;
      bld_lg_r     <= bld_lg_nxt;
      built_r      <= built_nxt;
      k_r          <= k_nxt;
      pos_r        <= pos_nxt;
      ph_r         <= ph_nxt;
      d_r          <= d_nxt;
      lvl_r        <= lvl_nxt;
      wr_cnt_r     <= wr_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  // ---------------- MAC pipeline ----------------
  // S0: addresses and twiddle fold; S1: memory data, products;
  // S2: accumulate; S3: round, saturate; then memory write.
  tw_addr_t tw_s, tw_c;
  assign tw_s = tw_lookup(ph_r);
  assign tw_c = tw_lookup(ph_r + AW'(QUARTER));

  logic signed [BIN_W-1:0]  op_a, op_b;
  logic signed [PROD_W:0]   term_d;
  logic signed [PROD_W+1:0] term_inv;
  logic signed [ACC_W-1:0]  rnd_re, rnd_im, rnd_inv;
  logic [5:0]               fwd_s;

  always_comb begin
    if (s1_ctl_r.zero) begin
      op_a = '0;
      op_b = '0;
    end else if (s1_ctl_r.fwd) begin
      op_a = BIN_W'($signed(frame_rdata));
      op_b = BIN_W'($signed(frame_rdata));
    end else begin
      op_a = spec_rdata[2*BIN_W-1:BIN_W];
      op_b = spec_rdata[BIN_W-1:0];
    end
  end

  assign term_d   = (PROD_W+1)'(pa_r) - (PROD_W+1)'(pb_r);
  assign term_inv = s2_ctl_r.dbl ? ((PROD_W+2)'(term_d) <<< 1) : (PROD_W+2)'(term_d);

  assign fwd_s   = 6'd13 + 6'(bld_lg_r);
  assign rnd_re  = (acc_re_r + (ACC_W'(1) <<< (fwd_s - 6'd1))) >>> fwd_s;
  assign rnd_im  = (acc_im_r + (ACC_W'(1) <<< (fwd_s - 6'd1))) >>> fwd_s;
  assign rnd_inv = (acc_re_r + (ACC_W'(1) <<< 26)) >>> 27;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
      wb_vld_r <= 1'b0;
    end else begin
      s1_ctl_r <= issue;
      s2_ctl_r <= s1_ctl_r;
      s3_ctl_r <= s2_ctl_r;
      wb_vld_r <= s3_ctl_r.vld & s3_ctl_r.last;
    end
  end

  always_ff @(posedge clk) begin
    sin_r <= tw_s.neg ? -$signed({1'b0, SINE_ROM[tw_s.idx]}) : $signed({1'b0, SINE_ROM[tw_s.idx]});
    cos_r <= tw_c.neg ? -$signed({1'b0, SINE_ROM[tw_c.idx]}) : $signed({1'b0, SINE_ROM[tw_c.idx]});
    pa_r  <= op_a * cos_r;
    pb_r  <= op_b * sin_r;
    if (s2_ctl_r.vld) begin
      if (s2_ctl_r.fwd) begin
        acc_re_r <= s2_ctl_r.first ? ACC_W'(pa_r) : acc_re_r + ACC_W'(pa_r);
        acc_im_r <= s2_ctl_r.first ? -ACC_W'(pb_r) : acc_im_r - ACC_W'(pb_r);
      end else begin
        acc_re_r <= s2_ctl_r.first ? ACC_W'(term_inv) : acc_re_r + ACC_W'(term_inv);
      end
    end
    wb_fwd_r <= s3_ctl_r.fwd;
    if (s3_ctl_r.fwd) wb_data_r <= {sat_bin(rnd_re), sat_bin(rnd_im)};
    else              wb_data_r <= {(2*BIN_W-SAMPLE_W)'(0), sat_smp(rnd_inv)};
  end

  assign spec_we   = wb_vld_r & wb_fwd_r;
  assign mip_we    = wb_vld_r & ~wb_fwd_r;
  assign mip_raddr = rd_addr;

  fbm_ram #(.W(SAMPLE_W), .D(MAX_FRAME)) u_frame_ram (
    .clk   (clk),
    .we    (frame_we),
    .waddr (load_cnt_r[AW-1:0]),
    .wdata (in_sample),
    .raddr (pos_r),
    .rdata (frame_rdata)
  );

  fbm_ram #(.W(2*BIN_W), .D(MAX_FRAME/2)) u_spec_ram (
    .clk   (clk),
    .we    (spec_we),
    .waddr (wr_cnt_r[SPEC_AW-1:0]),
    .wdata (wb_data_r),
    .raddr (k_r),
    .rdata (spec_rdata)
  );

  fbm_ram #(.W(SAMPLE_W), .D(2*MAX_FRAME)) u_mip_ram (
    .clk   (clk),
    .we    (mip_we),
    .waddr (wr_cnt_r),
    .wdata (wb_data_r[SAMPLE_W-1:0]),
    .raddr (mip_raddr),
    .rdata (mip_rdata)
  );

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  // ---------------- checks ----------------
  a_spec_wr_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    spec_we |-> (state_r == ST_FWD || state_r == ST_FWD_DRAIN))
    else $error("spectrum write outside forward pass");

  a_mip_wr_inv: assert property (@(posedge clk) disable iff (!rst_n)
    mip_we |-> (state_r == ST_INV || state_r == ST_INV_DRAIN))
    else $error("mip write outside inverse pass");

  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy raised without a transfer");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_IDLE))
    else $error("result while building or reading");

  a_mip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mip_we |-> ({1'b0, wr_cnt_r} < {bld_len, 1'b0}))
    else $error("mip write beyond level table");

endmodule
